// ===== sv/prm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types and constants of the peak and RMS level meter.
// ----------------------------------------------------------------------------
package prm_pkg;

   localparam int StoreDepth         = 8;
   localparam int DefaultMaxChannels = 8;
   localparam int QueueDepth         = 2;

   localparam logic [22:0] ClampLimit = 23'd4194304;

   localparam logic CmdAccumulate = 1'b0;
   localparam logic CmdConsume    = 1'b1;

   typedef struct packed {
      logic        consume;
      logic [2:0]  channel;
      logic [22:0] mag;
      logic [45:0] square;
      logic [3:0]  count;
   } queue_entry_type;

endpackage

// ===== sv/prm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_front
// Accepts request transfers, filters and clamps samples, squares them and
// tracks the number of channels seen.
// ----------------------------------------------------------------------------
module prm_front
   import prm_pkg::*;
#(
   parameter int MAX_CHANNELS = DefaultMaxChannels
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_command,
   input  logic [2:0]      req_channel,
   input  logic [23:0]     req_sample,
   input  logic            req_sample_finite,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   input  logic            queue_full,
   output logic            push,
   output queue_entry_type push_entry
);

   localparam int ChanLimit = (MAX_CHANNELS < StoreDepth) ? MAX_CHANNELS : StoreDepth;

   logic        capture_ff, capture_in;
   logic [3:0]  seen_ff, seen_in;
   logic        accept, in_range, acc_ok;
   logic [3:0]  ch_plus;
   logic [23:0] clamped;
   logic [22:0] mag;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign in_range  = {1'b0, req_channel} < 4'(ChanLimit);
   assign acc_ok    = accept && req_command == CmdAccumulate && capture_ff && in_range;
   assign ch_plus   = {1'b0, req_channel} + 4'd1;

   always_comb begin
      capture_in = capture_ff;
      if (csr_write_enable) begin
         capture_in = csr_write_data;
      end
      seen_in = seen_ff;
      if (acc_ok && seen_ff < ch_plus) begin
         seen_in = ch_plus;
      end
      if ($signed(req_sample) > $signed({1'b0, ClampLimit})) begin
         clamped = {1'b0, ClampLimit};
      end else if ($signed(req_sample) < -$signed({1'b0, ClampLimit})) begin
         clamped = {1'b0, ClampLimit};
      end else if (req_sample[23]) begin
         clamped = -req_sample;
      end else begin
         clamped = req_sample;
      end
   end

   assign mag  = clamped[22:0];
   assign push = (acc_ok && req_sample_finite) || (accept && req_command == CmdConsume);

   always_comb begin
      push_entry.consume = req_command == CmdConsume;
      push_entry.channel = req_channel;
      push_entry.mag     = mag;
      push_entry.square  = 46'(mag) * 46'(mag);
      push_entry.count   = seen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_ff <= 1'b0;
         seen_ff    <= 4'd0;
      end else begin
         capture_ff <= capture_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

// ===== sv/prm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_queue
// Short queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module prm_queue
   import prm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            full,
   input  logic            pop,
   output logic            not_empty,
   output queue_entry_type head
);

   localparam int PtrW = $clog2(QueueDepth);

   queue_entry_type        mem_ff [QueueDepth];
   logic [PtrW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]          count_ff, count_in;

   assign full      = count_ff == (PtrW + 1)'(QueueDepth);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/prm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_back
// Holds the per-channel accumulators, applies queued operations and produces
// the frame results through a shared divider and square-root sequencer.
// ----------------------------------------------------------------------------
module prm_back
   import prm_pkg::*;
#(
   parameter int MAX_CHANNELS = DefaultMaxChannels
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  queue_entry_type q_head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [2:0]      rsp_out_channel,
   output logic [22:0]     rsp_peak_level,
   output logic [22:0]     rsp_rms_level,
   output logic            rsp_channel_has_samples,
   output logic            rsp_frame_has_samples,
   output logic            rsp_last
);

   localparam int ChanLimit = (MAX_CHANNELS < StoreDepth) ? MAX_CHANNELS : StoreDepth;
   localparam int IdxW      = (ChanLimit > 1) ? $clog2(ChanLimit) : 1;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StLoad = 3'd1;
   localparam logic [2:0] StDiv  = 3'd2;
   localparam logic [2:0] StSqrt = 3'd3;
   localparam logic [2:0] StEmit = 3'd4;

   logic [22:0] peak_ff  [ChanLimit];
   logic [63:0] sum_ff   [ChanLimit];
   logic [31:0] cnt_ff   [ChanLimit];

   logic [2:0]  state_ff, state_in;
   logic [2:0]  c_ff, c_in;
   logic [3:0]  n_ff, n_in;
   logic        any_ff, any_in;
   logic        has_ff, has_in;
   logic [31:0] div_ff, div_in;
   logic [63:0] dq_ff, dq_in;
   logic [32:0] rem_ff, rem_in;
   logic [34:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  step_ff, step_in;

   logic        acc_we, clr_we, out_free, out_load, is_last;
   logic [IdxW-1:0] acc_idx, c_idx;
   logic [64:0] sum_add;
   logic [32:0] rem_sh;
   logic [34:0] srem_sh, trial;
   logic [22:0] rms_val;

   logic        rsp_valid_ff;
   logic [2:0]  out_ch_ff;
   logic [22:0] out_peak_ff, out_rms_ff;
   logic        out_has_ff, out_frame_ff, out_last_ff;

   assign acc_idx  = q_head.channel[IdxW-1:0];
   assign c_idx    = c_ff[IdxW-1:0];
   assign sum_add  = {1'b0, sum_ff[acc_idx]} + 65'(q_head.square);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last  = ({1'b0, c_ff} + 4'd1) == n_ff;
   assign rem_sh   = {rem_ff[31:0], dq_ff[63]};
   assign srem_sh  = {srem_ff[32:0], dq_ff[63:62]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign rms_val  = (root_ff > 32'(ClampLimit)) ? ClampLimit : root_ff[22:0];

   always_comb begin
      state_in = state_ff;
      c_in     = c_ff;
      n_in     = n_ff;
      any_in   = any_ff;
      has_in   = has_ff;
      div_in   = div_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      pop      = 1'b0;
      acc_we   = 1'b0;
      clr_we   = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (q_valid) begin
               pop = 1'b1;
               if (!q_head.consume) begin
                  acc_we = 1'b1;
               end else if (q_head.count != 4'd0) begin
                  c_in     = 3'd0;
                  n_in     = q_head.count;
                  any_in   = 1'b0;
                  state_in = StLoad;
               end
            end
         end
         StLoad: begin
            div_in  = cnt_ff[c_idx];
            dq_in   = sum_ff[c_idx];
            rem_in  = '0;
            srem_in = '0;
            root_in = '0;
            step_in = '0;
            has_in  = cnt_ff[c_idx] != 32'd0;
            any_in  = any_ff || (cnt_ff[c_idx] != 32'd0);
            state_in = (cnt_ff[c_idx] != 32'd0) ? StDiv : StEmit;
         end
         StDiv: begin
            if (rem_sh >= {1'b0, div_ff}) begin
               rem_in = rem_sh - {1'b0, div_ff};
               dq_in  = {dq_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               dq_in  = {dq_ff[62:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               step_in  = '0;
               state_in = StSqrt;
            end
         end
         StSqrt: begin
            dq_in = {dq_ff[61:0], 2'b00};
            if (srem_sh >= trial) begin
               srem_in = srem_sh - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = srem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd31) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (out_free) begin
               out_load = 1'b1;
               clr_we   = 1'b1;
               if (is_last) begin
                  state_in = StIdle;
               end else begin
                  c_in     = c_ff + 3'd1;
                  state_in = StLoad;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ChanLimit; i++) begin
            peak_ff[i] <= '0;
            sum_ff[i]  <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (acc_we) begin
         if (q_head.mag > peak_ff[acc_idx]) begin
            peak_ff[acc_idx] <= q_head.mag;
         end
         sum_ff[acc_idx] <= sum_add[64] ? '1 : sum_add[63:0];
         if (cnt_ff[acc_idx] != '1) begin
            cnt_ff[acc_idx] <= cnt_ff[acc_idx] + 32'd1;
         end
      end else if (clr_we) begin
         peak_ff[c_idx] <= '0;
         sum_ff[c_idx]  <= '0;
         cnt_ff[c_idx]  <= '0;
      end
   end

   always_ff @(posedge clock) begin
      c_ff    <= c_in;
      n_ff    <= n_in;
      any_ff  <= any_in;
      has_ff  <= has_in;
      div_ff  <= div_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (out_load) begin
         out_ch_ff    <= c_ff;
         out_peak_ff  <= peak_ff[c_idx];
         out_rms_ff   <= rms_val;
         out_has_ff   <= has_ff;
         out_frame_ff <= is_last && any_ff;
         out_last_ff  <= is_last;
      end
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_out_channel         = out_ch_ff;
   assign rsp_peak_level          = out_peak_ff;
   assign rsp_rms_level           = out_rms_ff;
   assign rsp_channel_has_samples = out_has_ff;
   assign rsp_frame_has_samples   = out_frame_ff;
   assign rsp_last                = out_last_ff;

endmodule

// ===== sv/peak_rms_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_rms_meter
// Per-channel audio peak and RMS level meter.
//
// A request transfer either accumulates one sample for a channel or consumes
// the frame. Samples are clamped and squared on entry and pass through a
// two-entry queue to the accumulator part. An accumulate transfer can be
// taken every cycle while the queue is not full; the accumulator part, while
// idle, retires one per cycle, so the queue only fills while a consume is
// in progress. A consume produces one response transfer for each channel
// from 0 up to the highest channel seen, channel 0 first, the final one
// flagged by last. Each channel with samples passes through a load, a
// 64-step divider, a 32-step square root and the output load; one without
// samples skips the divider and root. Responses sit in an output register;
// while the receiver stalls, the sequencer waits and the request side keeps
// filling the queue. Reset clears the capture enable, the seen-channel count
// and all accumulators at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module peak_rms_meter
   import prm_pkg::*;
#(
   parameter int MAX_CHANNELS = DefaultMaxChannels
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [2:0]  req_channel,
   input  logic [23:0] req_sample,
   input  logic        req_sample_finite,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_out_channel,
   output logic [22:0] rsp_peak_level,
   output logic [22:0] rsp_rms_level,
   output logic        rsp_channel_has_samples,
   output logic        rsp_frame_has_samples,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic            push, pop, q_full, q_valid;
   queue_entry_type push_entry, q_head;

   prm_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_sample        (req_sample),
      .req_sample_finite (req_sample_finite),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .queue_full        (q_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   prm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   prm_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_valid                 (q_valid),
      .q_head                  (q_head),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_out_channel         (rsp_out_channel),
      .rsp_peak_level          (rsp_peak_level),
      .rsp_rms_level           (rsp_rms_level),
      .rsp_channel_has_samples (rsp_channel_has_samples),
      .rsp_frame_has_samples   (rsp_frame_has_samples),
      .rsp_last                (rsp_last)
   );

endmodule

// ===== sv/prm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_checker
// Port-level checks of the level meter's response channel.
// ----------------------------------------------------------------------------
module prm_checker
   import prm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [22:0] rsp_peak_level,
   input logic [22:0] rsp_rms_level,
   input logic        rsp_channel_has_samples,
   input logic        rsp_frame_has_samples,
   input logic        rsp_last
);

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rms_level))
      else $error("response dropped while stalled");

   a_frame_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_frame_has_samples)
      else $error("frame flag outside the last transfer");

   a_empty_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_channel_has_samples |-> rsp_rms_level == 23'd0
         && rsp_peak_level == 23'd0)
      else $error("empty channel reports a level");

   a_levels_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms_level <= ClampLimit && rsp_peak_level <= ClampLimit)
      else $error("level beyond clamp limit");

endmodule

bind peak_rms_meter prm_checker u_prm_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_peak_level          (rsp_peak_level),
   .rsp_rms_level           (rsp_rms_level),
   .rsp_channel_has_samples (rsp_channel_has_samples),
   .rsp_frame_has_samples   (rsp_frame_has_samples),
   .rsp_last                (rsp_last)
);
